[rtl/flr_pkg.sv]
`timescale 1ns / 1ps

package flr_pkg;

  typedef logic [7:0] char_t;

  localparam char_t CHAR_NUL    = 8'h00;
  localparam char_t CHAR_TAB    = 8'h09;
  localparam char_t CHAR_CR     = 8'h0d;
  localparam char_t CHAR_SPACE  = 8'h20;
  localparam char_t CHAR_PLUS   = 8'h2b;
  localparam char_t CHAR_MINUS  = 8'h2d;
  localparam char_t CHAR_POINT  = 8'h2e;
  localparam char_t CHAR_ZERO   = 8'h30;
  localparam char_t CHAR_NINE   = 8'h39;
  localparam char_t CHAR_UP_A   = 8'h41;
  localparam char_t CHAR_UP_E   = 8'h45;
  localparam char_t CHAR_UP_F   = 8'h46;
  localparam char_t CHAR_UP_I   = 8'h49;
  localparam char_t CHAR_UP_N   = 8'h4e;
  localparam char_t CHAR_LO_A   = 8'h61;
  localparam char_t CHAR_LO_E   = 8'h65;
  localparam char_t CHAR_LO_F   = 8'h66;
  localparam char_t CHAR_LO_I   = 8'h69;
  localparam char_t CHAR_LO_N   = 8'h6e;

endpackage

[rtl/flr_if.sv]
`timescale 1ns / 1ps

interface flr_in_if;
  logic           valid;
  logic           ready;
  flr_pkg::char_t ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface flr_out_if;
  logic valid;
  logic ready;
  logic is_float;

  modport source (output valid, output is_float, input ready);
  modport sink   (input valid, input is_float, output ready);
endinterface

[rtl/float_literal_recognizer.sv]
`timescale 1ns / 1ps

// Checks byte strings for float literal syntax, one character per item on
// in_bus at one item per clock. A zero byte ends the string and, in the next
// cycle, yields a single item on out_bus whose is_float says whether the
// string was a valid literal; all other bytes yield nothing. The result sits
// in an output register; input stalls only while that register is full and
// not being drained, so characters flow back to back while out_bus is ready.
// The scanner state updates once per accepted byte.
module float_literal_recognizer (
  input  logic            clk,
  input  logic            rst_n,
  flr_in_if.sink          in_bus,
  flr_out_if.source       out_bus
);
  import flr_pkg::*;

  typedef enum logic [3:0] {
    PH_WS, PH_SIGNED, PH_INF1, PH_INF2, PH_INF3, PH_LEADPT,
    PH_RUN1, PH_AFTPT, PH_EXP, PH_EXPSGN, PH_RUN2
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   seen_point_r, seen_point_nxt;
  logic   seen_exp_r, seen_exp_nxt;
  logic   rejected_r, rejected_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_float_r, is_float_nxt;

  char_t  c;
  logic   step, term, accepting;
  logic   is_digit, is_sign, is_exp, is_ws;
  logic   is_l1, is_l2, is_l3;

  assign c        = in_bus.ch;
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign step     = in_bus.valid && in_bus.ready;
  assign term     = (c == CHAR_NUL);

  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
  assign is_exp   = (c == CHAR_LO_E) || (c == CHAR_UP_E);
  assign is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign is_l1    = (c == CHAR_LO_I) || (c == CHAR_UP_I) ||
                    (c == CHAR_LO_N) || (c == CHAR_UP_N);
  assign is_l2    = (c == CHAR_LO_N) || (c == CHAR_UP_N) ||
                    (c == CHAR_LO_A) || (c == CHAR_UP_A);
  assign is_l3    = (c == CHAR_LO_F) || (c == CHAR_UP_F) ||
                    (c == CHAR_LO_N) || (c == CHAR_UP_N);

  assign accepting = !rejected_r &&
                     ((phase_r == PH_INF3) || (phase_r == PH_RUN1) || (phase_r == PH_RUN2));

  always_comb begin
    phase_nxt      = phase_r;
    seen_point_nxt = seen_point_r;
    seen_exp_nxt   = seen_exp_r;
    rejected_nxt   = rejected_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    is_float_nxt   = is_float_r;
    if (step && term) begin
      out_valid_nxt  = 1'b1;
      is_float_nxt   = accepting;
      phase_nxt      = PH_WS;
      seen_point_nxt = 1'b0;
      seen_exp_nxt   = 1'b0;
      rejected_nxt   = 1'b0;
    end else if (step && !rejected_r) begin
      rejected_nxt = 1'b1;
      unique case (phase_r)
        PH_WS, PH_SIGNED: begin
          if (phase_r == PH_WS && is_ws) begin
            rejected_nxt = 1'b0;
          end else if (phase_r == PH_WS && is_sign) begin
            phase_nxt    = PH_SIGNED;
            rejected_nxt = 1'b0;
          end else if (is_l1) begin
            phase_nxt    = PH_INF1;
            rejected_nxt = 1'b0;
          end else if (c == CHAR_POINT) begin
            phase_nxt      = PH_LEADPT;
            seen_point_nxt = 1'b1;
            rejected_nxt   = 1'b0;
          end else if (is_digit) begin
            phase_nxt    = PH_RUN1;
            rejected_nxt = 1'b0;
          end
        end
        PH_INF1: begin
          if (is_l2) begin
            phase_nxt    = PH_INF2;
            rejected_nxt = 1'b0;
          end
        end
        PH_INF2: begin
          if (is_l3) begin
            phase_nxt    = PH_INF3;
            rejected_nxt = 1'b0;
          end
        end
        PH_LEADPT, PH_EXPSGN: begin
          if (is_digit) begin
            phase_nxt    = (phase_r == PH_LEADPT) ? PH_RUN1 : PH_RUN2;
            rejected_nxt = 1'b0;
          end
        end
        PH_RUN1: begin
          if (is_digit) begin
            rejected_nxt = 1'b0;
          end else if (c == CHAR_POINT && !seen_point_r) begin
            phase_nxt      = PH_AFTPT;
            seen_point_nxt = 1'b1;
            rejected_nxt   = 1'b0;
          end else if (is_exp) begin
            phase_nxt    = PH_EXP;
            seen_exp_nxt = 1'b1;
            rejected_nxt = 1'b0;
          end
        end
        PH_AFTPT: begin
          if (is_exp) begin
            phase_nxt    = PH_EXP;
            seen_exp_nxt = 1'b1;
            rejected_nxt = 1'b0;
          end else if (is_digit) begin
            phase_nxt    = PH_RUN2;
            rejected_nxt = 1'b0;
          end
        end
        PH_EXP: begin
          if (is_sign) begin
            phase_nxt    = PH_EXPSGN;
            rejected_nxt = 1'b0;
          end else if (is_digit) begin
            phase_nxt    = PH_RUN2;
            rejected_nxt = 1'b0;
          end
        end
        PH_RUN2: begin
          if (is_digit) begin
            rejected_nxt = 1'b0;
          end else if (is_exp && !seen_exp_r) begin
            phase_nxt    = PH_EXP;
            seen_exp_nxt = 1'b1;
            rejected_nxt = 1'b0;
          end
        end
        default: begin
          rejected_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WS;
      seen_point_r <= 1'b0;
      seen_exp_r   <= 1'b0;
      rejected_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      seen_point_r <= seen_point_nxt;
      seen_exp_r   <= seen_exp_nxt;
      rejected_r   <= rejected_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_float_r <= is_float_nxt;
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.is_float = is_float_r;

endmodule

[sim/tb_float_literal_recognizer.sv]
`timescale 1ns / 1ps

module tb_float_literal_recognizer;
  import flr_pkg::*;

  typedef enum logic [3:0] {
    SC_WS, SC_SIGNED, SC_WORD1, SC_WORD2, SC_WORD3, SC_LEADPT,
    SC_INT, SC_AFTPT, SC_EXP, SC_EXPSGN, SC_FRAC
  } scan_t;

  typedef enum logic [1:0] {
    PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH
  } pace_t;

  typedef struct {
    char_t ch;
    pace_t pace;
    bit    hold;
  } char_item_t;

  localparam int RANDOM_CHARS = 1350;
  localparam int HOLD_CYCLES  = 300;

  logic clk;
  logic rst_n;

  flr_in_if  in_bus();
  flr_out_if out_bus();

  float_literal_recognizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  char_item_t chars_to_send[$];
  bit         verdicts_due[$];
  pace_t      pace;
  logic       hold_req;
  int         hold_left;
  int         errors;
  int         sent;
  pace_t      gen_pace;
  bit         gen_hold;

  scan_t scan;
  bit    point_seen;
  bit    exp_seen;
  bit    scan_bad;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void scan_char(input char_t c, output bit done, output bit verdict);
    scan_t nx;
    bit    ok;
    bit    dig;
    bit    sgn;
    bit    ex;
    dig     = c >= CHAR_ZERO && c <= CHAR_NINE;
    sgn     = c == CHAR_PLUS || c == CHAR_MINUS;
    ex      = c == CHAR_LO_E || c == CHAR_UP_E;
    done    = 1'b0;
    verdict = 1'b0;
    nx      = scan;
    ok      = 1'b1;
    if (c == CHAR_NUL) begin
      done       = 1'b1;
      verdict    = !scan_bad && (scan == SC_WORD3 || scan == SC_INT || scan == SC_FRAC);
      scan       = SC_WS;
      point_seen = 1'b0;
      exp_seen   = 1'b0;
      scan_bad   = 1'b0;
    end else if (!scan_bad) begin
      case (scan)
        SC_WS, SC_SIGNED: begin
          if (scan == SC_WS && (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)))
            nx = SC_WS;
          else if (scan == SC_WS && sgn)
            nx = SC_SIGNED;
          else if (c inside {CHAR_LO_I, CHAR_UP_I, CHAR_LO_N, CHAR_UP_N})
            nx = SC_WORD1;
          else if (c == CHAR_POINT) begin
            point_seen = 1'b1;
            nx = SC_LEADPT;
          end else if (dig)
            nx = SC_INT;
          else
            ok = 1'b0;
        end
        SC_WORD1: begin
          if (c inside {CHAR_LO_N, CHAR_UP_N, CHAR_LO_A, CHAR_UP_A}) nx = SC_WORD2;
          else ok = 1'b0;
        end
        SC_WORD2: begin
          if (c inside {CHAR_LO_F, CHAR_UP_F, CHAR_LO_N, CHAR_UP_N}) nx = SC_WORD3;
          else ok = 1'b0;
        end
        SC_LEADPT: begin
          if (dig) nx = SC_INT;
          else ok = 1'b0;
        end
        SC_INT: begin
          if (dig)
            nx = SC_INT;
          else if (c == CHAR_POINT && !point_seen) begin
            point_seen = 1'b1;
            nx = SC_AFTPT;
          end else if (ex) begin
            exp_seen = 1'b1;
            nx = SC_EXP;
          end else
            ok = 1'b0;
        end
        SC_AFTPT: begin
          if (ex) begin
            exp_seen = 1'b1;
            nx = SC_EXP;
          end else if (dig)
            nx = SC_FRAC;
          else
            ok = 1'b0;
        end
        SC_EXP: begin
          if (sgn) nx = SC_EXPSGN;
          else if (dig) nx = SC_FRAC;
          else ok = 1'b0;
        end
        SC_EXPSGN: begin
          if (dig) nx = SC_FRAC;
          else ok = 1'b0;
        end
        SC_FRAC: begin
          if (dig)
            nx = SC_FRAC;
          else if (ex && !exp_seen) begin
            exp_seen = 1'b1;
            nx = SC_EXP;
          end else
            ok = 1'b0;
        end
        default: ok = 1'b0;
      endcase
      if (ok) scan = nx;
      else scan_bad = 1'b1;
    end
  endfunction

  task automatic push_char(input char_t c);
    char_item_t it;
    it.ch    = c;
    it.pace  = gen_pace;
    it.hold  = gen_hold;
    gen_hold = 1'b0;
    chars_to_send.push_back(it);
    sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(char_t'(s[i]));
    push_char(CHAR_NUL);
  endtask

  function automatic char_t pick_of4(input char_t a, input char_t b, input char_t c,
                                     input char_t d);
    case ($urandom_range(3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  function automatic char_t pick_digit();
    return char_t'(CHAR_ZERO + $urandom_range(9));
  endfunction

  function automatic char_t pick_ws();
    if ($urandom_range(1)) return CHAR_SPACE;
    return char_t'(CHAR_TAB + $urandom_range(4));
  endfunction

  function automatic char_t pick_char();
    case ($urandom_range(7))
      0: return pick_digit();
      1: return CHAR_POINT;
      2: return pick_of4(CHAR_LO_E, CHAR_UP_E, CHAR_LO_E, CHAR_UP_E);
      3: return pick_of4(CHAR_PLUS, CHAR_MINUS, CHAR_PLUS, CHAR_MINUS);
      4: return pick_ws();
      5: return pick_of4(CHAR_LO_I, CHAR_UP_N, CHAR_LO_A, CHAR_UP_F);
      default: return char_t'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic add_exponent(ref char_t s[$]);
    int n;
    s.push_back(pick_of4(CHAR_LO_E, CHAR_UP_E, CHAR_LO_E, CHAR_UP_E));
    case ($urandom_range(2))
      1: s.push_back(CHAR_PLUS);
      2: s.push_back(CHAR_MINUS);
      default: ;
    endcase
    n = $urandom_range(1, 2);
    repeat (n) s.push_back(pick_digit());
  endtask

  task automatic gen_string();
    char_t s[$];
    int    kind;
    int    n;
    int    pos;
    bit    leadpt;
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(0, 6);
      repeat (n) s.push_back($urandom_range(1) ? pick_char() : char_t'($urandom_range(1, 255)));
    end else begin
      n = $urandom_range(0, 2);
      repeat (n) s.push_back(pick_ws());
      case ($urandom_range(2))
        1: s.push_back(CHAR_PLUS);
        2: s.push_back(CHAR_MINUS);
        default: ;
      endcase
      if (kind < 25) begin
        s.push_back(pick_of4(CHAR_LO_I, CHAR_UP_I, CHAR_LO_N, CHAR_UP_N));
        s.push_back(pick_of4(CHAR_LO_N, CHAR_UP_N, CHAR_LO_A, CHAR_UP_A));
        s.push_back(pick_of4(CHAR_LO_F, CHAR_UP_F, CHAR_LO_N, CHAR_UP_N));
        if ($urandom_range(3) == 0) s.push_back(pick_char());
      end else begin
        leadpt = $urandom_range(4) == 0;
        if (leadpt) s.push_back(CHAR_POINT);
        n = $urandom_range(1, 4);
        repeat (n) s.push_back(pick_digit());
        case ($urandom_range(5))
          1: begin
            s.push_back(CHAR_POINT);
            n = $urandom_range(1, 3);
            repeat (n) s.push_back(pick_digit());
          end
          2: begin
            s.push_back(CHAR_POINT);
            add_exponent(s);
          end
          3: add_exponent(s);
          4: begin
            s.push_back(CHAR_POINT);
            n = $urandom_range(1, 3);
            repeat (n) s.push_back(pick_digit());
            add_exponent(s);
          end
          5: s.push_back(CHAR_POINT);
          default: ;
        endcase
        if ($urandom_range(9) == 0) add_exponent(s);
      end
      if ($urandom_range(99) < 20 && s.size() != 0) begin
        pos = $urandom_range(s.size() - 1);
        case ($urandom_range(2))
          0: s[pos] = char_t'($urandom_range(1, 255));
          1: s.delete(pos);
          default: s.insert(pos, pick_char());
        endcase
      end
    end
    foreach (s[i]) push_char(s[i]);
    push_char(CHAR_NUL);
  endtask

  always @(posedge clk) begin : drive
    bit         done;
    bit         verdict;
    bit         idle;
    bit         load;
    char_item_t it;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      hold_req     <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        scan_char(in_bus.ch, done, verdict);
        if (done) verdicts_due.push_back(verdict);
      end
      if (!in_bus.valid || in_bus.ready) begin
        idle = (pace == PACE_SEND_GAPS && $urandom_range(99) < 77) ||
               (pace == PACE_BOTH && $urandom_range(99) < 21);
        load = !idle && chars_to_send.size() != 0;
        if (load) begin
          it = chars_to_send.pop_front();
          in_bus.ch <= it.ch;
          pace      <= it.pace;
        end
        in_bus.valid <= load;
        hold_req     <= load && it.hold;
      end else begin
        hold_req <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : collect
    bit stall;
    bit want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected is_float=%0b at %0t", out_bus.is_float, $realtime);
        end else begin
          want = verdicts_due.pop_front();
          if (out_bus.is_float !== want) begin
            errors++;
            if (errors <= 10)
              $display("is_float mismatch: expected %0b, got %0b at %0t",
                       want, out_bus.is_float, $realtime);
          end
        end
      end
      stall = (pace == PACE_RECV_STALLS && $urandom_range(99) < 77) ||
              (pace == PACE_BOTH && $urandom_range(99) < 21);
      out_bus.ready <= hold_left == 0 && !stall;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.ch     = CHAR_NUL;
    out_bus.ready = 1'b0;
    pace          = PACE_FULL;
    hold_req      = 1'b0;
    hold_left     = 0;
    errors        = 0;
    sent          = 0;
    gen_pace      = PACE_FULL;
    gen_hold      = 1'b0;
    scan          = SC_WS;
    point_seen    = 1'b0;
    exp_seen      = 1'b0;
    scan_bad      = 1'b0;

    push_char(CHAR_NUL);
    push_text("\t ");
    push_text("+ 1");
    push_char(8'hff);
    push_char(CHAR_NUL);
    push_text("-nAN");
    push_text("1.e5");
    push_text("12.");
    push_text(".1.2");
    push_text("1e2e3");

    begin : fill
      int base;
      int r;
      bit hold_done;
      base      = sent;
      hold_done = 1'b0;
      while (sent - base < RANDOM_CHARS) begin
        r = sent - base;
        gen_pace = r < 340 ? PACE_FULL :
                   r < 680 ? PACE_SEND_GAPS :
                   r < 1020 ? PACE_RECV_STALLS : PACE_BOTH;
        if (!hold_done && r >= 150) begin
          gen_hold  = 1'b1;
          hold_done = 1'b1;
        end
        gen_string();
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_to_send.size() != 0 || in_bus.valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    errors += verdicts_due.size();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/flr_pkg.sv
rtl/flr_if.sv
rtl/float_literal_recognizer.sv
sim/tb_float_literal_recognizer.sv
